// File: rtl/core/tdpt_pkg.sv
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_OUT
  } tdpt_state_t;

  // status of the shared divider towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } tdpt_div_stat_t;

endpackage

// File: rtl/core/tdpt_if.sv
interface tdpt_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if;
  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, output prime_flag, input ready);
  modport sink   (input valid, input prime_flag, output ready);
endinterface

// File: rtl/core/tdpt_div.sv
module tdpt_div #(
  parameter int unsigned NW = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NW-1:0]            dividend,
  input  logic [NW-1:0]            divisor,
  output logic [NW-1:0]            quot,
  output logic [NW-1:0]            rem,
  output tdpt_pkg::tdpt_div_stat_t stat
);
  import tdpt_pkg::*;

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quot_r, quot_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          take;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quot_r[NW-1]};
  assign take  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[NW-2:0], take};
      rem_nxt  = take ? diff[NW-1:0] : trial[NW-1:0];
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot      = quot_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: rtl/core/trial_division_prime_test.sv
// Trial-division primality test. One signed candidate in, one prime_flag out.
// Negative values, 0, 1 and even values above 2 are settled at once (result
// offered the cycle after the item is taken); 2 is prime. An odd candidate n is
// divided by 3, 5, 7, ... on one shared restoring divider until the divisor
// exceeds the quotient or a remainder is zero. For each divisor the divider is
// loaded, works out the DATA_WIDTH-1 quotient bits, and the sequencer then
// decides on the result. The input is not ready again until the result has
// been taken.
module trial_division_prime_test #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  tdpt_in_if.sink    in_ch,
  tdpt_out_if.source out_ch
);
  import tdpt_pkg::*;

  localparam int unsigned NW = DATA_WIDTH - 1;

  tdpt_state_t    state_r, state_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic [NW-1:0]  d_r, d_nxt;
  logic           flag_r, flag_nxt;

  logic [NW-1:0]  cand_pos;
  logic           cand_trivial;
  logic           cand_flag;
  logic           in_acc;
  logic           div_start;
  logic [NW-1:0]  div_quot;
  logic [NW-1:0]  div_rem;
  tdpt_div_stat_t div_stat;
  logic           d_above;
  logic           rem_zero;

  // candidate reduced to its positive part, 0 when negative
  assign cand_pos = in_ch.candidate[DATA_WIDTH-1] ? '0 : in_ch.candidate[NW-1:0];

  always_comb begin
    cand_trivial = 1'b1;
    cand_flag    = 1'b0;
    if (cand_pos <= NW'(1)) begin
      cand_flag = 1'b0;
    end else if (cand_pos == NW'(2)) begin
      cand_flag = 1'b1;
    end else if (!cand_pos[0]) begin
      cand_flag = 1'b0;
    end else begin
      cand_trivial = 1'b0;
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign d_above  = d_r > div_quot;
  assign rem_zero = div_rem == '0;

  tdpt_div #(
    .NW(NW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(n_r),
    .divisor (d_r),
    .quot    (div_quot),
    .rem     (div_rem),
    .stat    (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = cand_trivial ? ST_OUT : ST_START;
        end
      end
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = (d_above || rem_zero) ? ST_OUT : ST_START;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and divider control
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    div_start    = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready  = 1'b1;
      ST_START: div_start    = 1'b1;
      ST_OUT:   out_ch.valid = 1'b1;
      default: begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        div_start    = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    flag_nxt = flag_r;
    if (in_acc) begin
      n_nxt    = cand_pos;
      d_nxt    = NW'(3);
      flag_nxt = cand_flag;
    end else if (state_r == ST_DIV && div_stat.done) begin
      // divisor past the square root wins over the remainder test
      if (d_above) begin
        flag_nxt = 1'b1;
      end else if (rem_zero) begin
        flag_nxt = 1'b0;
      end else begin
        d_nxt = d_r + NW'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    flag_r <= flag_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_ch.prime_flag = flag_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START |=> div_stat.busy)
    else $error("divider not running after start");

  a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START || state_r == ST_DIV) |-> (d_r[0] && n_r[0]))
    else $error("even divisor or candidate in the divide loop");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

endmodule
